/* rtl/qts_pkg.sv */
// ============================================================================
// qts_pkg
// Shared types, constants and helpers of the quoted token splitter.
// ============================================================================
package qts_pkg;

    // Result kinds, carried on the output tuser
    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    // Configuration register indexes
    localparam logic [1:0] REG_WHITE_SET   = 2'd0;
    localparam logic [1:0] REG_DELIM_SET   = 2'd1;
    localparam logic [1:0] REG_QUOTE_SET   = 2'd2;
    localparam logic [1:0] REG_TOKEN_LIMIT = 2'd3;

    // Register reset values
    localparam logic [31:0] WHITE_SET_RST   = 32'd538976521;
    localparam logic [31:0] DELIM_SET_RST   = 32'd44;
    localparam logic [31:0] QUOTE_SET_RST   = 32'd34;
    localparam logic [6:0]  TOKEN_LIMIT_RST = 7'd64;

    // Commands from controller to datapath
    typedef struct packed {
        logic  latch;        // capture the input item
        logic  do_char;      // apply the character to the scan state
        logic  flush_init;   // reset the read index
        logic  rd_issue;     // read token buffer at the read index
        logic  idx_inc;      // advance the read index
        logic  flush_clear;  // close the open token
        logic  load;         // load the output register
        kind_t load_kind;
        logic  load_last;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic term;          // held item ends the string
        logic in_token;      // a token is open
        logic pre_flush;     // open token is already full
        logic char_emits;    // char would produce results when scanning starts
        logic char_empty;    // char is a delimiter while skipping
        logic char_flush;    // char closes the token after being applied
        logic kept_zero;     // open token has nothing to emit
        logic idx_last;      // read index at the final kept character
        logic slot_free;     // output register can take a result
    } sts_t;

    // Byte match against up to four slots; zero bytes never match
    function automatic logic in_set(input logic [31:0] set, input logic [7:0] c,
                                    input int slots);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (k < slots && set[8*k +: 8] == c)
            begin
                hit = 1'b1;
            end
        end
        return hit && (c != 8'd0);
    endfunction

endpackage

/* rtl/qts_ram.sv */
// ============================================================================
// qts_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module qts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/qts_datapath.sv */
// ============================================================================
// qts_datapath
// Configuration, scan state, token buffer and output register.
// ============================================================================
module qts_datapath #(
    parameter int MAX_TOKEN_BYTES = 64,
    parameter int SET_SLOTS       = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic [7:0]        in_char,
    input  logic              in_term,
    input  qts_pkg::cmd_t     cmd,
    output qts_pkg::sts_t     sts,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_char,
    output logic [1:0]        out_kind,
    output logic              out_last
);

    localparam int AW = $clog2(MAX_TOKEN_BYTES);
    localparam logic [8:0] MAX9 = 9'(MAX_TOKEN_BYTES);

    typedef enum logic [1:0] {
        MODE_SKIP,
        MODE_PLAIN,
        MODE_QUOTED
    } mode_t;

    logic [31:0] white_set_reg, delim_set_reg, quote_set_reg;
    logic [6:0]  token_limit_reg;

    mode_t       mode_reg;
    logic [AW-1:0] count_reg, kept_reg, idx_reg;
    logic [7:0]  char_reg;
    logic        term_reg;

    logic        out_valid_reg, out_last_reg;
    logic [7:0]  out_char_reg;
    logic [1:0]  out_kind_reg;

    logic [8:0]  lim9, cap9;
    logic [AW-1:0] cap;
    logic        is_white, is_quote, is_delim;
    logic        cap_one, count_hits;
    logic        store_now;
    logic        char_empty, char_flush;
    logic [AW-1:0] waddr;
    logic [7:0]  rdata;
    logic        slot_free;

    // Clamp the limit and derive the per-token character capacity
    always_comb
    begin
        lim9 = {2'b00, token_limit_reg};
        if (lim9 < 9'd2)
        begin
            lim9 = 9'd2;
        end
        else if (lim9 > MAX9)
        begin
            lim9 = MAX9;
        end
        cap9 = lim9 - 9'd1;
        cap  = cap9[AW-1:0];
    end

    always_comb
    begin
        is_white   = qts_pkg::in_set(white_set_reg, char_reg, SET_SLOTS);
        is_quote   = qts_pkg::in_set(quote_set_reg, char_reg, SET_SLOTS);
        is_delim   = qts_pkg::in_set(delim_set_reg, char_reg, SET_SLOTS);
        cap_one    = (cap == AW'(1));
        count_hits = ({1'b0, count_reg} + {{AW{1'b0}}, 1'b1}) >= {1'b0, cap};
    end

    // Decide what the held character does
    always_comb
    begin
        store_now  = 1'b0;
        waddr      = count_reg;
        char_empty = 1'b0;
        char_flush = 1'b0;
        case (mode_reg)
            MODE_SKIP:
            begin
                waddr = '0;
                store_now  = !is_white && !is_quote && !is_delim;
                char_empty = !is_white && !is_quote && is_delim;
                char_flush = store_now && cap_one;
            end
            MODE_PLAIN:
            begin
                store_now  = !is_delim;
                char_flush = is_delim || count_hits;
            end
            MODE_QUOTED:
            begin
                store_now  = !is_quote;
                char_flush = is_quote || count_hits;
            end
            default:
            begin
                store_now = 1'b0;
            end
        endcase
    end

    assign slot_free      = !out_valid_reg || out_ready;
    assign sts.term       = term_reg;
    assign sts.in_token   = (mode_reg != MODE_SKIP);
    assign sts.pre_flush  = (mode_reg != MODE_SKIP) && (count_reg >= cap);
    assign sts.char_emits = !is_white && !is_quote && (is_delim || cap_one);
    assign sts.char_empty = char_empty;
    assign sts.char_flush = char_flush;
    assign sts.kept_zero  = (kept_reg == '0);
    assign sts.idx_last   = (idx_reg == kept_reg - AW'(1));
    assign sts.slot_free  = slot_free;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            white_set_reg   <= qts_pkg::WHITE_SET_RST;
            delim_set_reg   <= qts_pkg::DELIM_SET_RST;
            quote_set_reg   <= qts_pkg::QUOTE_SET_RST;
            token_limit_reg <= qts_pkg::TOKEN_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                qts_pkg::REG_WHITE_SET:   white_set_reg   <= cfg_data;
                qts_pkg::REG_DELIM_SET:   delim_set_reg   <= cfg_data;
                qts_pkg::REG_QUOTE_SET:   quote_set_reg   <= cfg_data;
                qts_pkg::REG_TOKEN_LIMIT: token_limit_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Held input item
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            char_reg <= in_char;
            term_reg <= in_term || (in_char == 8'd0);
        end
    end

    // Scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_SKIP;
            count_reg <= '0;
            kept_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            if (cmd.flush_clear)
            begin
                mode_reg  <= MODE_SKIP;
                count_reg <= '0;
                kept_reg  <= '0;
            end
            else if (cmd.do_char)
            begin
                case (mode_reg)
                    MODE_SKIP:
                    begin
                        if (!is_white && is_quote)
                        begin
                            mode_reg  <= MODE_QUOTED;
                            count_reg <= '0;
                            kept_reg  <= '0;
                        end
                        else if (store_now)
                        begin
                            mode_reg  <= MODE_PLAIN;
                            count_reg <= AW'(1);
                            kept_reg  <= AW'(1);
                        end
                    end
                    MODE_PLAIN:
                    begin
                        if (store_now)
                        begin
                            count_reg <= count_reg + AW'(1);
                            if (count_reg == '0 || !is_white)
                            begin
                                kept_reg <= count_reg + AW'(1);
                            end
                        end
                    end
                    MODE_QUOTED:
                    begin
                        if (store_now)
                        begin
                            count_reg <= count_reg + AW'(1);
                            kept_reg  <= count_reg + AW'(1);
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.flush_init)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + AW'(1);
            end
        end
    end

    qts_ram #(
        .WIDTH (8),
        .DEPTH (MAX_TOKEN_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (cmd.do_char && store_now),
        .waddr (waddr),
        .wdata (char_reg),
        .re    (cmd.rd_issue),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_char_reg <= (cmd.load_kind == qts_pkg::KIND_CHAR) ? rdata : 8'd0;
            out_kind_reg <= cmd.load_kind;
            out_last_reg <= cmd.load_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_kind  = out_kind_reg;
    assign out_last  = out_last_reg;

endmodule

/* rtl/qts_ctrl.sv */
// ============================================================================
// qts_ctrl
// Sequencer: evaluates one item, drives token flushes and marker results.
// ============================================================================
module qts_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  qts_pkg::sts_t sts,
    output qts_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_FL_CHECK,
        ST_FL_EMPTY,
        ST_FL_RD,
        ST_FL_WAIT,
        ST_EMIT_EMPTY,
        ST_EMIT_END
    } state_t;

    state_t state_reg, state_next;
    state_t resume_reg, resume_next;
    logic   flush_last_reg, flush_last_next;

    always_comb
    begin
        state_next      = state_reg;
        resume_next     = resume_reg;
        flush_last_next = flush_last_reg;
        cmd             = '0;
        cmd.load_kind   = qts_pkg::KIND_CHAR;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (sts.term)
                begin
                    if (sts.in_token)
                    begin
                        cmd.flush_init  = 1'b1;
                        flush_last_next = 1'b0;
                        resume_next     = ST_EMIT_END;
                        state_next      = ST_FL_CHECK;
                    end
                    else
                    begin
                        state_next = ST_EMIT_END;
                    end
                end
                else if (sts.pre_flush)
                begin
                    // token full before this char: flush, then re-evaluate
                    cmd.flush_init  = 1'b1;
                    flush_last_next = !sts.char_emits;
                    resume_next     = ST_EVAL;
                    state_next      = ST_FL_CHECK;
                end
                else
                begin
                    cmd.do_char = 1'b1;
                    if (sts.char_empty)
                    begin
                        state_next = ST_EMIT_EMPTY;
                    end
                    else if (sts.char_flush)
                    begin
                        cmd.flush_init  = 1'b1;
                        flush_last_next = 1'b1;
                        resume_next     = ST_IDLE;
                        state_next      = ST_FL_CHECK;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FL_CHECK:
            begin
                state_next = sts.kept_zero ? ST_FL_EMPTY : ST_FL_RD;
            end
            ST_FL_EMPTY:
            begin
                if (sts.slot_free)
                begin
                    cmd.load        = 1'b1;
                    cmd.load_kind   = qts_pkg::KIND_EMPTY;
                    cmd.load_last   = flush_last_reg;
                    cmd.flush_clear = 1'b1;
                    state_next      = resume_reg;
                end
            end
            ST_FL_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_FL_WAIT;
            end
            ST_FL_WAIT:
            begin
                if (sts.slot_free)
                begin
                    cmd.load      = 1'b1;
                    cmd.load_kind = qts_pkg::KIND_CHAR;
                    cmd.load_last = sts.idx_last && flush_last_reg;
                    if (sts.idx_last)
                    begin
                        cmd.flush_clear = 1'b1;
                        state_next      = resume_reg;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_FL_RD;
                    end
                end
            end
            ST_EMIT_EMPTY:
            begin
                if (sts.slot_free)
                begin
                    cmd.load      = 1'b1;
                    cmd.load_kind = qts_pkg::KIND_EMPTY;
                    cmd.load_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_EMIT_END:
            begin
                if (sts.slot_free)
                begin
                    cmd.load      = 1'b1;
                    cmd.load_kind = qts_pkg::KIND_END;
                    cmd.load_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            resume_reg     <= ST_IDLE;
            flush_last_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            resume_reg     <= resume_next;
            flush_last_reg <= flush_last_next;
        end
    end

endmodule

/* rtl/quoted_token_splitter_top.sv */
// ============================================================================
// quoted_token_splitter_top
// Byte-stream tokenizer with whitespace skip, quoting and trailing trim.
// ============================================================================
// The block takes one input transfer at a time. A byte that only updates the
// scan state is accepted and then evaluated. A byte or terminator that
// finishes a token adds a check step and then, per emitted character, a read
// step and a load step on the token buffer's single registered read port; an
// empty-token or end-of-string marker adds a load step. A stalled output holds
// each load step until the output register frees up. The token buffer needs
// no clearing pass after reset: only characters of the open token are ever
// read. Configuration writes belong to idle periods only.
// ============================================================================
module quoted_token_splitter_top #(
    parameter int MAX_TOKEN_BYTES = 64,
    parameter int SET_SLOTS       = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_char
    input  logic        s_tuser,   // [0] terminator
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_char
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // last result caused by one input transfer
);

    qts_pkg::cmd_t cmd;
    qts_pkg::sts_t sts;

    // Sequencer: one input item in flight, results pushed through the
    // output register as it frees up
    qts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: config registers, scan state, token buffer, output register
    qts_datapath #(
        .MAX_TOKEN_BYTES (MAX_TOKEN_BYTES),
        .SET_SLOTS       (SET_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_char   (s_tdata),
        .in_term   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .out_kind  (m_tuser),
        .out_last  (m_tlast)
    );

endmodule

/* rtl/qts_checker.sv */
// ============================================================================
// qts_checker
// Port-level checks of the quoted token splitter, bound to the top level.
// ============================================================================
module qts_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled output result changed");

    // Markers carry no character
    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != qts_pkg::KIND_CHAR) |-> m_tdata == 8'd0)
        else $error("marker result with nonzero character");

    // End of string always closes the run of one input
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == qts_pkg::KIND_END) |-> m_tlast)
        else $error("end-of-string marker without last");

    // One item at a time: no transfer right after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while previous item in work");

endmodule

bind quoted_token_splitter_top qts_checker u_qts_checker (.*);
